>>> hdl/fsbd_pkg.sv
// ----------------------------------------------------------------------------
// fsbd_pkg
// Shared types, codes and sizes of the flux stream byte decoder.
// ----------------------------------------------------------------------------
package fsbd_pkg;

    // Index records taken per buffer before further index blocks are dropped
    localparam int MAX_INDEX_RECORDS = 256;
    localparam int IDX_CNT_W         = $clog2(MAX_INDEX_RECORDS + 1);

    // Front-to-back queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Result kinds
    localparam logic [2:0] KIND_FLUX   = 3'd0;
    localparam logic [2:0] KIND_INDEX  = 3'd1;
    localparam logic [2:0] KIND_INFO   = 3'd2;
    localparam logic [2:0] KIND_END    = 3'd3;
    localparam logic [2:0] KIND_STATUS = 3'd4;

    // Final status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_MISSING_DATA = 3'd1;
    localparam logic [2:0] ST_MISSING_END  = 3'd2;
    localparam logic [2:0] ST_DEV_BUFFER   = 3'd3;
    localparam logic [2:0] ST_DEV_NO_INDEX = 3'd4;

    // Cell stream opcodes
    localparam logic [7:0] OP_FLUX2_MAX = 8'h07;
    localparam logic [7:0] OP_NOP1      = 8'h08;
    localparam logic [7:0] OP_NOP2      = 8'h09;
    localparam logic [7:0] OP_NOP3      = 8'h0A;
    localparam logic [7:0] OP_OVL16     = 8'h0B;
    localparam logic [7:0] OP_FLUX3     = 8'h0C;
    localparam logic [7:0] OP_OOB       = 8'h0D;

    // Out-of-band block types
    localparam logic [7:0] OOB_INFO  = 8'h01;
    localparam logic [7:0] OOB_INDEX = 8'h02;
    localparam logic [7:0] OOB_END   = 8'h03;
    localparam logic [7:0] OOB_EOF   = 8'h0D;

    localparam logic [31:0] OVL_STEP     = 32'h0001_0000;
    localparam int          GATHER_BYTES = 12;
    localparam logic [15:0] INFO_MIN     = 16'd8;
    localparam logic [15:0] INDEX_MIN    = 16'd12;
    localparam logic [15:0] END_MIN      = 16'd8;

    // End-of-stream result codes that raise a device status
    localparam logic [31:0] END_RES_BUFFER   = 32'd1;
    localparam logic [31:0] END_RES_NO_INDEX = 32'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] flux_value;
        logic [31:0] position;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [2:0]  final_status;
        logic        last_of_run;
    } t_out_item;

    // What one accepted byte leaves for the back end
    typedef struct packed {
        logic      has_rec;
        t_out_item rec;
        logic      has_final;
        logic [2:0] status;
    } t_event;

endpackage

>>> hdl/fsbd_front.sv
// ----------------------------------------------------------------------------
// fsbd_front
// Byte parser: decodes cells and out-of-band blocks, one byte per cycle while the event output is ready.
// ----------------------------------------------------------------------------
module fsbd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  fsbd_pkg::t_in_item i_item,
    output logic              o_ev_valid,
    input  logic              i_ev_ready,
    output fsbd_pkg::t_event  o_ev
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FLUX2,
        PH_FLUX3,
        PH_NOP,
        PH_OOBHDR,
        PH_OOBPAY
    } t_phase;

    t_phase r_phase, n_phase;
    logic [7:0]  r_opcode, n_opcode;
    logic [15:0] r_idx, n_idx;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_size, n_size;
    logic [7:0]  r_flux_hi, n_flux_hi;
    logic [7:0]  r_gather [fsbd_pkg::GATHER_BYTES];
    logic [7:0]  n_gather [fsbd_pkg::GATHER_BYTES];
    logic [31:0] r_ovl, n_ovl;
    logic [31:0] r_pos, n_pos;
    logic [2:0]  r_status, n_status;
    logic        r_saw_end, n_saw_end;
    logic        r_halted, n_halted;
    logic [fsbd_pkg::IDX_CNT_W-1:0] r_taken, n_taken;

    logic        accept;
    logic        finish;
    logic [7:0]  b;
    logic [15:0] need;
    logic [31:0] w0, w1, w2;
    logic [2:0]  st;
    fsbd_pkg::t_event ev;

    assign o_ready = i_ev_ready;
    assign accept  = i_valid && o_ready;
    assign b       = i_item.data_byte;

    always_comb begin
        n_phase   = r_phase;
        n_opcode  = r_opcode;
        n_idx     = r_idx;
        n_type    = r_type;
        n_size    = r_size;
        n_flux_hi = r_flux_hi;
        n_gather  = r_gather;
        n_ovl     = r_ovl;
        n_pos     = r_pos;
        n_status  = r_status;
        n_saw_end = r_saw_end;
        n_halted  = r_halted;
        n_taken   = r_taken;
        finish    = 1'b0;
        need      = (r_opcode == fsbd_pkg::OP_NOP2) ? 16'd2 : 16'd3;
        st        = fsbd_pkg::ST_OK;
        w0        = '0;
        w1        = '0;
        w2        = '0;
        ev        = '0;

        if (accept && !r_halted) begin
            case (r_phase)
                PH_IDLE: begin
                    n_opcode = b;
                    n_idx    = 16'd1;
                    if (b <= fsbd_pkg::OP_FLUX2_MAX) begin
                        n_flux_hi = b;
                        n_phase   = PH_FLUX2;
                    end else if (b == fsbd_pkg::OP_NOP1) begin
                        n_pos = r_pos + 32'd1;
                    end else if (b == fsbd_pkg::OP_NOP2 || b == fsbd_pkg::OP_NOP3) begin
                        n_phase = PH_NOP;
                    end else if (b == fsbd_pkg::OP_OVL16) begin
                        n_ovl = r_ovl + fsbd_pkg::OVL_STEP;
                        n_pos = r_pos + 32'd1;
                    end else if (b == fsbd_pkg::OP_FLUX3) begin
                        n_flux_hi = 8'h00;
                        n_phase   = PH_FLUX3;
                    end else if (b == fsbd_pkg::OP_OOB) begin
                        n_phase = PH_OOBHDR;
                    end else begin
                        ev.has_rec            = 1'b1;
                        ev.rec.kind           = fsbd_pkg::KIND_FLUX;
                        ev.rec.flux_value     = {24'h0, b} + r_ovl;
                        ev.rec.position       = r_pos;
                        n_ovl                 = '0;
                        n_pos                 = r_pos + 32'd1;
                    end
                end
                PH_FLUX2: begin
                    ev.has_rec        = 1'b1;
                    ev.rec.kind       = fsbd_pkg::KIND_FLUX;
                    ev.rec.flux_value = {16'h0, r_flux_hi, b} + r_ovl;
                    ev.rec.position   = r_pos;
                    n_ovl             = '0;
                    n_pos             = r_pos + 32'd2;
                    n_phase           = PH_IDLE;
                end
                PH_FLUX3: begin
                    if (r_idx == 16'd1) begin
                        n_flux_hi = b;
                        n_idx     = 16'd2;
                    end else begin
                        ev.has_rec        = 1'b1;
                        ev.rec.kind       = fsbd_pkg::KIND_FLUX;
                        ev.rec.flux_value = {16'h0, r_flux_hi, b} + r_ovl;
                        ev.rec.position   = r_pos;
                        n_ovl             = '0;
                        n_pos             = r_pos + 32'd3;
                        n_phase           = PH_IDLE;
                    end
                end
                PH_NOP: begin
                    n_idx = r_idx + 16'd1;
                    if (n_idx >= need) begin
                        n_pos   = r_pos + {16'h0, need};
                        n_phase = PH_IDLE;
                    end
                end
                PH_OOBHDR: begin
                    if (r_idx == 16'd1) begin
                        n_type = b;
                        n_idx  = 16'd2;
                    end else if (r_idx == 16'd2) begin
                        n_size = {8'h00, b};
                        n_idx  = 16'd3;
                    end else begin
                        n_size = {b, r_size[7:0]};
                        if (r_type == fsbd_pkg::OOB_EOF) begin
                            // end of file: ignore everything up to the last byte
                            n_saw_end = 1'b1;
                            n_halted  = 1'b1;
                            n_phase   = PH_IDLE;
                        end else begin
                            for (int k = 0; k < fsbd_pkg::GATHER_BYTES; k++) begin
                                n_gather[k] = 8'h00;
                            end
                            n_idx = '0;
                            if (n_size == 16'd0) begin
                                finish = 1'b1;
                            end else begin
                                n_phase = PH_OOBPAY;
                            end
                        end
                    end
                end
                PH_OOBPAY: begin
                    if (r_idx < 16'(fsbd_pkg::GATHER_BYTES)) begin
                        n_gather[r_idx[3:0]] = b;
                    end
                    n_idx = r_idx + 16'd1;
                    if (n_idx >= r_size) begin
                        finish = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            if (finish) begin
                // take the gathered words before a last byte clears them
                w0 = {n_gather[3], n_gather[2], n_gather[1], n_gather[0]};
                w1 = {n_gather[7], n_gather[6], n_gather[5], n_gather[4]};
                w2 = {n_gather[11], n_gather[10], n_gather[9], n_gather[8]};
                n_phase = PH_IDLE;
                case (r_type)
                    fsbd_pkg::OOB_INFO: begin
                        if (n_size >= fsbd_pkg::INFO_MIN) begin
                            ev.has_rec     = 1'b1;
                            ev.rec.kind    = fsbd_pkg::KIND_INFO;
                            ev.rec.word_a  = w0;
                            ev.rec.word_b  = w1;
                        end
                    end
                    fsbd_pkg::OOB_INDEX: begin
                        if (n_size >= fsbd_pkg::INDEX_MIN &&
                            r_taken < fsbd_pkg::IDX_CNT_W'(fsbd_pkg::MAX_INDEX_RECORDS)) begin
                            ev.has_rec      = 1'b1;
                            ev.rec.kind     = fsbd_pkg::KIND_INDEX;
                            ev.rec.position = w0;
                            ev.rec.word_a   = w1;
                            ev.rec.word_b   = w2;
                            n_taken         = r_taken + 1'b1;
                        end
                    end
                    fsbd_pkg::OOB_END: begin
                        n_saw_end = 1'b1;
                        if (n_size >= fsbd_pkg::END_MIN) begin
                            if (w1 == fsbd_pkg::END_RES_BUFFER) begin
                                n_status = fsbd_pkg::ST_DEV_BUFFER;
                            end else if (w1 == fsbd_pkg::END_RES_NO_INDEX) begin
                                n_status = fsbd_pkg::ST_DEV_NO_INDEX;
                            end
                            ev.has_rec      = 1'b1;
                            ev.rec.kind     = fsbd_pkg::KIND_END;
                            ev.rec.position = w0;
                            ev.rec.word_a   = w1;
                        end
                    end
                    default: begin
                        // info string and unknown types: drop
                    end
                endcase
            end
        end

        if (accept && i_item.last_byte) begin
            if (!n_halted && n_phase != PH_IDLE) begin
                st = fsbd_pkg::ST_MISSING_DATA;
            end else begin
                st = n_status;
            end
            if (st == fsbd_pkg::ST_OK && !n_saw_end) begin
                st = fsbd_pkg::ST_MISSING_END;
            end
            ev.has_final = 1'b1;
            ev.status    = st;
            // start the next buffer from a clean state
            n_phase   = PH_IDLE;
            n_opcode  = '0;
            n_idx     = '0;
            n_type    = '0;
            n_size    = '0;
            n_flux_hi = '0;
            for (int k = 0; k < fsbd_pkg::GATHER_BYTES; k++) begin
                n_gather[k] = 8'h00;
            end
            n_ovl     = '0;
            n_pos     = '0;
            n_status  = fsbd_pkg::ST_OK;
            n_saw_end = 1'b0;
            n_halted  = 1'b0;
            n_taken   = '0;
        end

        ev.rec.last_of_run = ev.has_rec && !ev.has_final;
    end

    assign o_ev_valid = accept && (ev.has_rec || ev.has_final);
    assign o_ev       = ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_opcode  <= '0;
            r_idx     <= '0;
            r_type    <= '0;
            r_size    <= '0;
            r_flux_hi <= '0;
            for (int k = 0; k < fsbd_pkg::GATHER_BYTES; k++) begin
                r_gather[k] <= 8'h00;
            end
            r_ovl     <= '0;
            r_pos     <= '0;
            r_status  <= fsbd_pkg::ST_OK;
            r_saw_end <= 1'b0;
            r_halted  <= 1'b0;
            r_taken   <= '0;
        end else begin
            r_phase   <= n_phase;
            r_opcode  <= n_opcode;
            r_idx     <= n_idx;
            r_type    <= n_type;
            r_size    <= n_size;
            r_flux_hi <= n_flux_hi;
            r_gather  <= n_gather;
            r_ovl     <= n_ovl;
            r_pos     <= n_pos;
            r_status  <= n_status;
            r_saw_end <= n_saw_end;
            r_halted  <= n_halted;
            r_taken   <= n_taken;
        end
    end

    a_halt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (r_phase == PH_IDLE && r_saw_end))
        else $error("halted parser left idle phase or missed end mark");

endmodule

>>> hdl/fsbd_queue.sv
// ----------------------------------------------------------------------------
// fsbd_queue
// Short event queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module fsbd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  fsbd_pkg::t_event i_push_ev,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output fsbd_pkg::t_event o_pop_ev
);

    fsbd_pkg::t_event r_mem [fsbd_pkg::Q_DEPTH];
    logic [fsbd_pkg::Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [fsbd_pkg::Q_CW-1:0] r_count;
    logic push, pop;

    assign o_push_ready = (r_count != fsbd_pkg::Q_CW'(fsbd_pkg::Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_ev     = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= fsbd_pkg::Q_CW'(fsbd_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == fsbd_pkg::Q_CW'(fsbd_pkg::Q_DEPTH))
            |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

>>> hdl/fsbd_back.sv
// ----------------------------------------------------------------------------
// fsbd_back
// Result sequencer: unpacks queued events into result items.
// ----------------------------------------------------------------------------
module fsbd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ev_valid,
    output logic                o_ev_ready,
    input  fsbd_pkg::t_event    i_ev,
    output logic                o_valid,
    input  logic                i_ready,
    output fsbd_pkg::t_out_item o_item
);

    logic                r_valid;
    fsbd_pkg::t_out_item r_item;
    logic                r_pend_final;
    logic [2:0]          r_pend_status;
    logic                slot_free;
    fsbd_pkg::t_out_item final_item;
    fsbd_pkg::t_out_item ev_final;

    assign slot_free  = !r_valid || i_ready;
    assign o_ev_ready = slot_free && !r_pend_final;

    always_comb begin
        final_item              = '0;
        final_item.kind         = fsbd_pkg::KIND_STATUS;
        final_item.final_status = r_pend_status;
        final_item.last_of_run  = 1'b1;
        ev_final                = '0;
        ev_final.kind           = fsbd_pkg::KIND_STATUS;
        ev_final.final_status   = i_ev.status;
        ev_final.last_of_run    = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_pend_final  <= 1'b0;
            r_pend_status <= fsbd_pkg::ST_OK;
        end else if (slot_free) begin
            if (r_pend_final) begin
                r_item       <= final_item;
                r_valid      <= 1'b1;
                r_pend_final <= 1'b0;
            end else if (i_ev_valid) begin
                r_valid <= 1'b1;
                if (i_ev.has_rec) begin
                    // record first, hold the status for the next slot
                    r_item        <= i_ev.rec;
                    r_pend_final  <= i_ev.has_final;
                    r_pend_status <= i_ev.status;
                end else begin
                    r_item <= ev_final;
                end
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    a_pend_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_final |-> r_valid && !r_item.last_of_run)
        else $error("pending status without a record in the output slot");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_item.kind == fsbd_pkg::KIND_STATUS) |-> r_item.last_of_run)
        else $error("status item not marked last");

endmodule

>>> hdl/flux_stream_byte_decoder.sv
// ----------------------------------------------------------------------------
// flux_stream_byte_decoder
// Decodes a captured flux cell stream, one byte per item, into flux values,
// index, stream info, stream end and final status items.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------
//  input   | i_valid / o_ready   | i_item  (data_byte, last_byte)
//  output  | o_valid / i_ready   | o_item  (kind .. last_of_run)
//
//  One input byte is taken per cycle while the four-entry event queue has
//  room; the parser decodes it in the cycle of acceptance.
//  A byte that causes two items (a record and the final status) occupies
//  the output register with each in turn, record first; bytes causing none take no output slot.
//  Reset (i_rst_n low, synchronous) returns the parser to its idle phase
//  and empties the queue and the output register.
//  A stalled output fills the queue, then drops o_ready until an entry leaves.
// ----------------------------------------------------------------------------
module flux_stream_byte_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  fsbd_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output fsbd_pkg::t_out_item o_item
);

    logic             fq_valid, fq_ready;
    fsbd_pkg::t_event fq_ev;
    logic             qb_valid, qb_ready;
    fsbd_pkg::t_event qb_ev;

    fsbd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_ev_valid (fq_valid),
        .i_ev_ready (fq_ready),
        .o_ev       (fq_ev)
    );

    fsbd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_ev    (fq_ev),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop_ev     (qb_ev)
    );

    fsbd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev_valid (qb_valid),
        .o_ev_ready (qb_ready),
        .i_ev       (qb_ev),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of flux_stream_byte_decoder. Builds capture buffers byte by byte
// (flux cells, no-ops, overflow, out-of-band blocks, end and EOF marks, cut
// blocks), decodes each accepted byte in a local model and checks every
// output item in order against it, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          RANDOM_BYTES = 1150;
    localparam int          TAIL_CYCLES  = 32;
    localparam logic [7:0]  OP_FLUX2_MIN = 8'h00;
    localparam logic [7:0]  FLUX1_MIN    = 8'h0E;
    localparam logic [7:0]  OOB_STRING   = 8'h04;

    typedef enum logic [2:0] {
        P_IDLE, P_FLUX2, P_FLUX3, P_NOP, P_OOB_HEAD, P_OOB_BODY
    } t_parse;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    fsbd_pkg::t_in_item  i_item  = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    fsbd_pkg::t_out_item o_item;

    flux_stream_byte_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Decoder model state
    t_parse      parse_st;
    logic [7:0]  blk_op;
    logic [15:0] blk_idx;
    logic [7:0]  oob_kind;
    logic [15:0] oob_len;
    logic [31:0] gather [3];
    logic [31:0] ovl_pending;
    logic [31:0] cell_pos;
    logic [2:0]  run_code;
    bit          end_seen;
    bit          halted;
    int          index_taken;

    fsbd_pkg::t_out_item byte_records[$];
    fsbd_pkg::t_out_item pending_records[$];
    logic [7:0]          stream_bytes[$];

    bit          pace_on = 1'b1;
    int unsigned ready_hold = 0;
    int          cycles = 0;
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          live_bytes = 0;
    int          buffers_sent = 0;
    int          records_checked = 0;
    int          kind_seen [5] = '{0, 0, 0, 0, 0};

    function automatic void clear_decoder();
        parse_st    = P_IDLE;
        blk_op      = '0;
        blk_idx     = '0;
        oob_kind    = '0;
        oob_len     = '0;
        gather      = '{32'h0, 32'h0, 32'h0};
        ovl_pending = '0;
        cell_pos    = '0;
        run_code    = fsbd_pkg::ST_OK;
        end_seen    = 1'b0;
        halted      = 1'b0;
        index_taken = 0;
    endfunction

    function automatic void add_record(input logic [2:0] kind, input logic [31:0] fv,
                                       input logic [31:0] pos, input logic [31:0] wa,
                                       input logic [31:0] wb, input logic [2:0] fs);
        fsbd_pkg::t_out_item it;
        it              = '0;
        it.kind         = kind;
        it.flux_value   = fv;
        it.position     = pos;
        it.word_a       = wa;
        it.word_b       = wb;
        it.final_status = fs;
        byte_records.push_back(it);
    endfunction

    function automatic void take_flux(input logic [31:0] ticks, input logic [31:0] len);
        add_record(fsbd_pkg::KIND_FLUX, ticks + ovl_pending, cell_pos, '0, '0,
                   fsbd_pkg::ST_OK);
        ovl_pending = '0;
        cell_pos    = cell_pos + len;
        parse_st    = P_IDLE;
    endfunction

    function automatic void close_block();
        if (oob_kind == fsbd_pkg::OOB_INFO) begin
            if (oob_len >= fsbd_pkg::INFO_MIN)
                add_record(fsbd_pkg::KIND_INFO, '0, '0, gather[0], gather[1],
                           fsbd_pkg::ST_OK);
        end else if (oob_kind == fsbd_pkg::OOB_INDEX) begin
            if (oob_len >= fsbd_pkg::INDEX_MIN &&
                index_taken < fsbd_pkg::MAX_INDEX_RECORDS) begin
                add_record(fsbd_pkg::KIND_INDEX, '0, gather[0], gather[1], gather[2],
                           fsbd_pkg::ST_OK);
                index_taken++;
            end
        end else if (oob_kind == fsbd_pkg::OOB_END) begin
            end_seen = 1'b1;
            if (oob_len >= fsbd_pkg::END_MIN) begin
                if (gather[1] == fsbd_pkg::END_RES_BUFFER)
                    run_code = fsbd_pkg::ST_DEV_BUFFER;
                else if (gather[1] == fsbd_pkg::END_RES_NO_INDEX)
                    run_code = fsbd_pkg::ST_DEV_NO_INDEX;
                add_record(fsbd_pkg::KIND_END, '0, gather[0], gather[1], '0,
                           fsbd_pkg::ST_OK);
            end
        end
        parse_st = P_IDLE;
    endfunction

    // Work out the items one accepted byte causes and queue them
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        logic [15:0]         nop_len;
        logic [2:0]          st;
        fsbd_pkg::t_out_item it;
        int                  slot;
        byte_records.delete();
        if (!halted) begin
            case (parse_st)
                P_IDLE: begin
                    blk_op  = b;
                    blk_idx = 16'd1;
                    if (b <= fsbd_pkg::OP_FLUX2_MAX) begin
                        gather[0] = {16'h0, b, 8'h00};
                        parse_st  = P_FLUX2;
                    end else if (b == fsbd_pkg::OP_NOP1) begin
                        cell_pos = cell_pos + 1;
                    end else if (b == fsbd_pkg::OP_NOP2 || b == fsbd_pkg::OP_NOP3) begin
                        parse_st = P_NOP;
                    end else if (b == fsbd_pkg::OP_OVL16) begin
                        ovl_pending = ovl_pending + fsbd_pkg::OVL_STEP;
                        cell_pos    = cell_pos + 1;
                    end else if (b == fsbd_pkg::OP_FLUX3) begin
                        gather[0] = '0;
                        parse_st  = P_FLUX3;
                    end else if (b == fsbd_pkg::OP_OOB) begin
                        parse_st = P_OOB_HEAD;
                    end else begin
                        take_flux(32'(b), 1);
                    end
                end
                P_FLUX2: take_flux(gather[0] | 32'(b), 2);
                P_FLUX3: begin
                    if (blk_idx == 16'd1) begin
                        gather[0] = {16'h0, b, 8'h00};
                        blk_idx   = 16'd2;
                    end else begin
                        take_flux(gather[0] | 32'(b), 3);
                    end
                end
                P_NOP: begin
                    nop_len = (blk_op == fsbd_pkg::OP_NOP2) ? 16'd2 : 16'd3;
                    blk_idx = blk_idx + 1;
                    if (blk_idx >= nop_len) begin
                        cell_pos = cell_pos + 32'(nop_len);
                        parse_st = P_IDLE;
                    end
                end
                P_OOB_HEAD: begin
                    if (blk_idx == 16'd1) begin
                        oob_kind = b;
                        blk_idx  = 16'd2;
                    end else if (blk_idx == 16'd2) begin
                        oob_len = {8'h00, b};
                        blk_idx = 16'd3;
                    end else begin
                        oob_len[15:8] = b;
                        if (oob_kind == fsbd_pkg::OOB_EOF) begin
                            end_seen = 1'b1;
                            halted   = 1'b1;
                            parse_st = P_IDLE;
                        end else begin
                            gather  = '{32'h0, 32'h0, 32'h0};
                            blk_idx = '0;
                            if (oob_len == 16'd0)
                                close_block();
                            else
                                parse_st = P_OOB_BODY;
                        end
                    end
                end
                default: begin
                    if (blk_idx < fsbd_pkg::GATHER_BYTES) begin
                        slot         = int'(blk_idx >> 2);
                        gather[slot] = gather[slot] | (32'(b) << (8 * blk_idx[1:0]));
                    end
                    blk_idx = blk_idx + 1;
                    if (blk_idx >= oob_len)
                        close_block();
                end
            endcase
        end
        if (last) begin
            if (!halted && parse_st != P_IDLE)
                run_code = fsbd_pkg::ST_MISSING_DATA;
            st = run_code;
            if (st == fsbd_pkg::ST_OK && !end_seen)
                st = fsbd_pkg::ST_MISSING_END;
            add_record(fsbd_pkg::KIND_STATUS, '0, '0, '0, '0, st);
            clear_decoder();
        end
        foreach (byte_records[i]) begin
            it             = byte_records[i];
            it.last_of_run = (i == byte_records.size() - 1);
            pending_records.push_back(it);
        end
    endfunction

    // Leave valid high after acceptance; the next call lowers it or replaces the item
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = pace_on ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= {b, last};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (!halted)
            live_bytes++;
        bytes_sent++;
        decode_byte(b, last);
    endtask

    // Lower valid, then wait for every expected item
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_records.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_bytes.size(); i++) begin
            if ($urandom_range(0, 199) == 0)
                drain_results();
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
        end
        stream_bytes.delete();
        buffers_sent++;
    endtask

    function automatic void put_fill(input int n);
        repeat (n) stream_bytes.push_back(8'($urandom));
    endfunction

    function automatic void put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            stream_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void put_head(input logic [7:0] kind, input logic [15:0] size);
        stream_bytes.push_back(fsbd_pkg::OP_OOB);
        stream_bytes.push_back(kind);
        stream_bytes.push_back(size[7:0]);
        stream_bytes.push_back(size[15:8]);
    endfunction

    function automatic void put_end(input logic [31:0] result);
        put_head(fsbd_pkg::OOB_END, fsbd_pkg::END_MIN);
        put_word($urandom);
        put_word(result);
    endfunction

    function automatic void put_eof();
        put_head(fsbd_pkg::OOB_EOF, 16'($urandom));
    endfunction

    function automatic logic [31:0] draw_end_code();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 32'd0;
        else if (r < 70)
            return fsbd_pkg::END_RES_BUFFER;
        else if (r < 90)
            return fsbd_pkg::END_RES_NO_INDEX;
        return $urandom;
    endfunction

    function automatic void add_random_element();
        int unsigned r;
        logic [7:0]  kind;
        logic [15:0] size;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            stream_bytes.push_back(8'($urandom_range(FLUX1_MIN, 255)));
        end else if (r < 55) begin
            stream_bytes.push_back(8'($urandom_range(OP_FLUX2_MIN, fsbd_pkg::OP_FLUX2_MAX)));
            put_fill(1);
        end else if (r < 63) begin
            stream_bytes.push_back(fsbd_pkg::OP_FLUX3);
            put_fill(2);
        end else if (r < 66) begin
            stream_bytes.push_back(fsbd_pkg::OP_NOP1);
        end else if (r < 69) begin
            stream_bytes.push_back(fsbd_pkg::OP_NOP2);
            put_fill(1);
        end else if (r < 72) begin
            stream_bytes.push_back(fsbd_pkg::OP_NOP3);
            put_fill(2);
        end else if (r < 79) begin
            stream_bytes.push_back(fsbd_pkg::OP_OVL16);
        end else if (r < 97) begin
            case ($urandom_range(0, 4))
                0:       kind = fsbd_pkg::OOB_INFO;
                1:       kind = fsbd_pkg::OOB_INDEX;
                2:       kind = fsbd_pkg::OOB_END;
                3:       kind = OOB_STRING;
                default: kind = 8'($urandom);
            endcase
            if (kind == fsbd_pkg::OOB_END && $urandom_range(0, 1) == 0) begin
                put_end(draw_end_code());
            end else begin
                size = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(17, 40))
                                                   : 16'($urandom_range(0, 16));
                put_head(kind, size);
                put_fill(int'(size));
            end
        end else begin
            put_fill(1);
        end
    endfunction

    // Output side: check each item against the oldest expectation, then stall
    task automatic report_mismatch(input string what, input fsbd_pkg::t_out_item want,
                                   input fsbd_pkg::t_out_item got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch (%s) at cycle %0d", what, cycles);
            $display("  expected kind %0d flux %08h pos %08h a %08h b %08h st %0d last %0d",
                     want.kind, want.flux_value, want.position, want.word_a, want.word_b,
                     want.final_status, want.last_of_run);
            $display("  got      kind %0d flux %08h pos %08h a %08h b %08h st %0d last %0d",
                     got.kind, got.flux_value, got.position, got.word_a, got.word_b,
                     got.final_status, got.last_of_run);
        end
    endtask

    always @(posedge i_clk) begin : rx_side
        fsbd_pkg::t_out_item want;
        int unsigned         stall;
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout with %0d items outstanding", pending_records.size());
            $display("flux_stream_byte_decoder verification failed");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            records_checked++;
            if (o_item.kind <= fsbd_pkg::KIND_STATUS)
                kind_seen[o_item.kind]++;
            if (pending_records.size() == 0) begin
                report_mismatch("unexpected item", '0, o_item);
            end else begin
                want = pending_records.pop_front();
                if (o_item.kind !== want.kind || o_item.flux_value !== want.flux_value ||
                    o_item.position !== want.position || o_item.word_a !== want.word_a ||
                    o_item.word_b !== want.word_b ||
                    o_item.final_status !== want.final_status ||
                    o_item.last_of_run !== want.last_of_run)
                    report_mismatch("field", want, o_item);
            end
            stall = pace_on ? $urandom_range(0, 11) : 0;
            if (stall == 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready    <= 1'b0;
                ready_hold <= stall;
            end
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            if (ready_hold == 1)
                i_ready <= 1'b1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Every cell kind at its extremes; the buffer closes with no end mark
    task automatic test_cells();
        stream_bytes = '{OP_FLUX2_MIN, 8'h00, fsbd_pkg::OP_FLUX2_MAX, 8'hFF,
                         fsbd_pkg::OP_FLUX3, 8'h00, 8'h00, fsbd_pkg::OP_FLUX3, 8'hFF, 8'hFF,
                         FLUX1_MIN, 8'hFF, fsbd_pkg::OP_NOP1, fsbd_pkg::OP_NOP2, 8'h55,
                         fsbd_pkg::OP_NOP3, 8'hAA, 8'h55, fsbd_pkg::OP_OVL16,
                         fsbd_pkg::OP_OVL16, 8'h80, fsbd_pkg::OP_OVL16, 8'h03, 8'h21};
        send_stream();
        drain_results();
    endtask

    // Records, short payloads, device result codes
    task automatic test_oob_records();
        put_head(fsbd_pkg::OOB_INFO, fsbd_pkg::INFO_MIN);
        put_word(32'hFFFF_FFFF);
        put_word(32'h0000_0000);
        put_head(fsbd_pkg::OOB_INDEX, fsbd_pkg::INDEX_MIN);
        put_word(32'h0000_0000);
        put_word(32'hFFFF_FFFF);
        put_word(32'h8000_0001);
        put_head(fsbd_pkg::OOB_INFO, fsbd_pkg::INFO_MIN - 1);
        put_fill(int'(fsbd_pkg::INFO_MIN) - 1);
        put_head(fsbd_pkg::OOB_INDEX, fsbd_pkg::INDEX_MIN - 1);
        put_fill(int'(fsbd_pkg::INDEX_MIN) - 1);
        put_head(fsbd_pkg::OOB_INDEX, 16'd20);
        put_fill(20);
        put_head(fsbd_pkg::OOB_END, 16'd0);
        put_head(fsbd_pkg::OOB_INFO, 16'd0);
        stream_bytes.push_back(FLUX1_MIN);
        put_end(fsbd_pkg::END_RES_BUFFER);
        send_stream();
        stream_bytes.push_back(8'hC3);
        put_head(fsbd_pkg::OOB_END, 16'd12);
        put_word($urandom);
        put_word(fsbd_pkg::END_RES_NO_INDEX);
        put_word($urandom);
        send_stream();
        drain_results();
    endtask

    // Bytes after the end-of-file header are ignored
    task automatic test_end_of_file();
        stream_bytes.push_back(FLUX1_MIN);
        stream_bytes.push_back(fsbd_pkg::OP_OVL16);
        put_eof();
        stream_bytes.push_back(fsbd_pkg::OP_FLUX3);
        stream_bytes.push_back(fsbd_pkg::OP_OOB);
        put_fill(3);
        send_stream();
        put_end(fsbd_pkg::END_RES_BUFFER);
        put_eof();
        send_stream();
        put_eof();
        send_stream();
        drain_results();
    endtask

    // Buffers that end inside a block
    task automatic test_truncation();
        stream_bytes = '{fsbd_pkg::OP_FLUX3, 8'h12};
        send_stream();
        stream_bytes = '{fsbd_pkg::OP_NOP2};
        send_stream();
        stream_bytes = '{fsbd_pkg::OP_OOB};
        send_stream();
        put_end(fsbd_pkg::END_RES_BUFFER);
        put_head(fsbd_pkg::OOB_END, fsbd_pkg::END_MIN);
        put_fill(2);
        send_stream();
        stream_bytes = '{fsbd_pkg::OP_OOB, fsbd_pkg::OOB_EOF, 8'h00};
        send_stream();
        drain_results();
    endtask

    // Payloads past the gather window and sizes with the high byte set
    task automatic test_long_payload();
        put_head(fsbd_pkg::OOB_INFO, 16'h0110);
        put_fill(16'h0110);
        stream_bytes.push_back(8'h9A);
        put_head(fsbd_pkg::OOB_INFO, 16'hFFFF);
        put_fill(20);
        send_stream();
        drain_results();
    endtask

    // Mostly well-formed buffers with random content, some cut short or noisy
    task automatic test_random_streams();
        int start;
        int unsigned r;
        start = live_bytes;
        while (live_bytes - start < RANDOM_BYTES) begin
            pace_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 40)) add_random_element();
            r = $urandom_range(0, 99);
            if (r < 40) begin
                put_end(draw_end_code());
                put_eof();
                put_fill($urandom_range(0, 4));
            end else if (r < 55) begin
                put_eof();
                put_fill($urandom_range(0, 4));
            end else if (r < 75) begin
                // close without any end mark
            end else if (r < 95) begin
                case ($urandom_range(0, 4))
                    0: stream_bytes.push_back(fsbd_pkg::OP_FLUX3);
                    1: stream_bytes.push_back(
                           8'($urandom_range(OP_FLUX2_MIN, fsbd_pkg::OP_FLUX2_MAX)));
                    2: begin
                        stream_bytes.push_back(fsbd_pkg::OP_NOP3);
                        put_fill($urandom_range(0, 1));
                    end
                    3: begin
                        stream_bytes.push_back(fsbd_pkg::OP_OOB);
                        put_fill($urandom_range(0, 2));
                    end
                    default: begin
                        put_head(8'($urandom_range(fsbd_pkg::OOB_INFO, OOB_STRING)),
                                 16'($urandom_range(1, 65535)));
                        put_fill($urandom_range(0, 12));
                    end
                endcase
            end else begin
                stream_bytes.delete();
                put_fill(1);
            end
            send_stream();
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end
        pace_on = 1'b1;
        drain_results();
    endtask

    initial begin
        clear_decoder();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_cells();
        test_oob_records();
        test_end_of_file();
        test_truncation();
        test_long_payload();
        test_random_streams();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d bytes (%0d decoded) in %0d buffers; checked %0d items.",
                 bytes_sent, live_bytes, buffers_sent, records_checked);
        $display("Items by kind: flux %0d, index %0d, info %0d, end %0d, status %0d.",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
        if (mismatches == 0 && pending_records.size() == 0) begin
            $display("flux_stream_byte_decoder verification clean");
        end else begin
            $display("%0d mismatches, %0d items never arrived", mismatches,
                     pending_records.size());
            $display("flux_stream_byte_decoder verification failed");
        end
        $finish;
    end

endmodule
